@@ rtl/neighbor_liveness_table_top_assert.svh @@
// assertion macros for the neighbor liveness table
`ifndef NEIGHBOR_LIVENESS_TABLE_TOP_ASSERT_SVH
`define NEIGHBOR_LIVENESS_TABLE_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define NLT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define NLT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/nlt_pkg.sv @@
// types and constants shared by the neighbor liveness table modules
`timescale 1ns / 1ps
package nlt_pkg;

  localparam logic FUNC_PONG  = 1'b0;
  localparam logic FUNC_CHECK = 1'b1;

  localparam logic [2:0] EV_STABLE      = 3'd0;
  localparam logic [2:0] EV_NEW         = 3'd1;
  localparam logic [2:0] EV_RTT_CHANGED = 3'd2;
  localparam logic [2:0] EV_REFRESHED   = 3'd3;
  localparam logic [2:0] EV_DOWN        = 3'd4;

  localparam logic [31:0] TIMEOUT_RESET = 32'd1000;

  localparam int Q_DEPTH = 2;
  localparam int Q_PW    = 1;
  localparam int Q_CW    = 2;

  // one classified item on its way to the back end
  typedef struct packed {
    logic        func;
    logic [3:0]  port;
    logic [15:0] sender_id;
    logic [31:0] rtt;
    logic [31:0] now;
  } nlt_cmd_t;

  // queue status seen by both ends
  typedef struct packed {
    logic full;
    logic empty;
  } nlt_qstat_t;

  // one table entry
  typedef struct packed {
    logic [15:0] id;
    logic [31:0] rtt;
    logic [31:0] last_heard;
  } nlt_entry_t;

endpackage

@@ rtl/nlt_front.sv @@
// front end: unpacks and classifies items, computes the pong rtt
`timescale 1ns / 1ps
module nlt_front import nlt_pkg::*; #(
  parameter int NUM_PORTS = 16
) (
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [87:0] s_axis_tdata,
  input  logic       s_axis_tuser,
  input  nlt_qstat_t q_stat_i,
  output logic       push_o,
  output nlt_cmd_t   cmd_o
);

  localparam logic [6:0] NP_W = 7'(NUM_PORTS);

  logic [3:0]  port;
  logic [31:0] sent_time;
  logic [31:0] now;
  logic        drop;

  assign port      = s_axis_tdata[3:0];
  assign sent_time = s_axis_tdata[51:20];
  assign now       = s_axis_tdata[83:52];

  // a pong on a port outside the table makes no result
  assign drop = (s_axis_tuser == FUNC_PONG) && ({3'b000, port} >= NP_W);

  assign s_axis_tready = !q_stat_i.full;
  assign push_o        = s_axis_tvalid && !q_stat_i.full && !drop;

  always_comb begin
    cmd_o.func      = s_axis_tuser;
    cmd_o.port      = port;
    cmd_o.sender_id = s_axis_tdata[19:4];
    cmd_o.rtt       = now - sent_time;
    cmd_o.now       = now;
  end

endmodule

@@ rtl/nlt_fifo.sv @@
// short command queue between front and back end
`timescale 1ns / 1ps
module nlt_fifo import nlt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  nlt_cmd_t   data_i,
  input  logic       pop_i,
  output nlt_cmd_t   data_o,
  output nlt_qstat_t stat_o
);

  nlt_cmd_t          slot_q [Q_DEPTH];
  logic [Q_PW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [Q_PW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [Q_CW-1:0]   count_q, count_d;
  logic              do_push;
  logic              do_pop;

  assign stat_o.full  = (count_q == Q_CW'(Q_DEPTH));
  assign stat_o.empty = (count_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign data_o       = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == Q_PW'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == Q_PW'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

@@ rtl/nlt_back.sv @@
// back end: neighbor table, pong update, liveness scan and output register
`timescale 1ns / 1ps
module nlt_back import nlt_pkg::*; #(
  parameter int NUM_PORTS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [31:0] link_timeout_i,
  input  nlt_qstat_t  q_stat_i,
  input  nlt_cmd_t    q_data_i,
  output logic        pop_o,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,
  output logic        m_axis_tlast
);

  localparam int PW = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_PONG = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;
  localparam logic [1:0] ST_END  = 2'd3;

  nlt_entry_t mem [NUM_PORTS];
  nlt_entry_t rd_q;
  logic             rd_en;
  logic [PW-1:0]    rd_addr;
  logic             we;
  logic [PW-1:0]    wr_addr;
  nlt_entry_t       wr_data;

  logic [1:0]       state_q, state_d;
  nlt_cmd_t         cmd_q, cmd_d;
  logic [PW-1:0]    idx_q, idx_d;
  logic [NUM_PORTS-1:0] valid_q, valid_d;

  logic             pend_valid_q, pend_valid_d;
  logic [3:0]       pend_port_q, pend_port_d;
  logic [15:0]      pend_id_q, pend_id_d;
  logic [31:0]      pend_rtt_q, pend_rtt_d;

  logic             out_valid_q, out_valid_d;
  logic [2:0]       out_event_q, out_event_d;
  logic [3:0]       out_port_q, out_port_d;
  logic [15:0]      out_id_q, out_id_d;
  logic [31:0]      out_rtt_q, out_rtt_d;
  logic             out_last_q, out_last_d;

  logic             out_free;
  logic [PW-1:0]    pong_idx;
  logic [31:0]      age;
  logic             expired;

  assign out_free = !out_valid_q || m_axis_tready;
  assign pong_idx = PW'(cmd_q.port);
  assign age      = cmd_q.now - rd_q.last_heard;
  assign expired  = valid_q[idx_q] && (age > link_timeout_i);

  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    idx_d        = idx_q;
    valid_d      = valid_q;
    pend_valid_d = pend_valid_q;
    pend_port_d  = pend_port_q;
    pend_id_d    = pend_id_q;
    pend_rtt_d   = pend_rtt_q;
    out_event_d  = out_event_q;
    out_port_d   = out_port_q;
    out_id_d     = out_id_q;
    out_rtt_d    = out_rtt_q;
    out_last_d   = out_last_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    pop_o        = 1'b0;
    rd_en        = 1'b0;
    rd_addr      = '0;
    we           = 1'b0;
    wr_addr      = pong_idx;
    wr_data      = '{id: cmd_q.sender_id, rtt: cmd_q.rtt, last_heard: cmd_q.now};

    case (state_q)
      ST_IDLE: begin
        if (!q_stat_i.empty) begin
          pop_o = 1'b1;
          cmd_d = q_data_i;
          rd_en = 1'b1;
          if (q_data_i.func == FUNC_PONG) begin
            rd_addr = PW'(q_data_i.port);
            state_d = ST_PONG;
          end else begin
            idx_d        = '0;
            pend_valid_d = 1'b0;
            state_d      = ST_SCAN;
          end
        end
      end
      ST_PONG: begin
        if (out_free) begin
          we          = 1'b1;
          out_valid_d = 1'b1;
          out_port_d  = cmd_q.port;
          out_id_d    = cmd_q.sender_id;
          out_rtt_d   = cmd_q.rtt;
          out_last_d  = 1'b1;
          if (!valid_q[pong_idx]) begin
            out_event_d        = EV_NEW;
            valid_d[pong_idx]  = 1'b1;
          end else begin
            // an occupied port keeps its stored id
            wr_data.id  = rd_q.id;
            out_event_d = (rd_q.rtt != cmd_q.rtt) ? EV_RTT_CHANGED : EV_REFRESHED;
          end
          state_d = ST_IDLE;
        end
      end
      ST_SCAN: begin
        // hold the scan while an older removal waits for the output register and this entry expires too
        if (!(expired && pend_valid_q && !out_free)) begin
          if (expired) begin
            valid_d[idx_q] = 1'b0;
            if (pend_valid_q) begin
              out_valid_d = 1'b1;
              out_event_d = EV_DOWN;
              out_port_d  = pend_port_q;
              out_id_d    = pend_id_q;
              out_rtt_d   = pend_rtt_q;
              out_last_d  = 1'b0;
            end
            pend_valid_d = 1'b1;
            pend_port_d  = 4'(idx_q);
            pend_id_d    = rd_q.id;
            pend_rtt_d   = rd_q.rtt;
          end
          if (idx_q == PW'(NUM_PORTS - 1)) begin
            state_d = ST_END;
          end else begin
            idx_d   = idx_q + 1'b1;
            rd_en   = 1'b1;
            rd_addr = idx_q + 1'b1;
          end
        end
      end
      ST_END: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_last_d  = 1'b1;
          if (pend_valid_q) begin
            out_event_d = EV_DOWN;
            out_port_d  = pend_port_q;
            out_id_d    = pend_id_q;
            out_rtt_d   = pend_rtt_q;
          end else begin
            out_event_d = EV_STABLE;
            out_port_d  = '0;
            out_id_d    = '0;
            out_rtt_d   = '0;
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      valid_q      <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      idx_q        <= '0;
    end else begin
      state_q      <= state_d;
      valid_q      <= valid_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
      idx_q        <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    pend_port_q <= pend_port_d;
    pend_id_q   <= pend_id_d;
    pend_rtt_q  <= pend_rtt_d;
    out_event_q <= out_event_d;
    out_port_q  <= out_port_d;
    out_id_q    <= out_id_d;
    out_rtt_q   <= out_rtt_d;
    out_last_q  <= out_last_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_rtt_q, out_id_q, out_port_q, out_event_q};
  assign m_axis_tlast  = out_last_q;

endmodule

@@ rtl/neighbor_liveness_table_top.sv @@
// neighbor liveness table top level: front end, command queue, table back end
//
//  channel   dir  handshake                     payload
//  s_axis    in   s_axis_tvalid/s_axis_tready   tdata: port, sender_id, sent_time, now
//                                               tuser: func
//  m_axis    out  m_axis_tvalid/m_axis_tready   tdata: event_res, out_port, neighbor_id,
//                                               rtt; tlast: last
//  cfg       in   cfg_we_i                      cfg_wdata_i: link_timeout
//
//  in the back end a pong reads the table, then updates the entry and the result
//  a check dispatches, then reads one table entry per cycle while the scan is not held,
//  through the single read port of the entry memory, and ends with the final word
//  the queue keeps taking words while the back end works, until its two slots fill;
//  a stall holds the scan only when a removal waits and another entry expires
//  reset clears all valid bits and loads link_timeout with 1000; no clearing pass
`timescale 1ns / 1ps
module neighbor_liveness_table_top import nlt_pkg::*; #(
  parameter int NUM_PORTS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [87:0] s_axis_tdata,  // port[3:0], sender_id[19:4], sent_time[51:20],
                                     // now[83:52], zero[87:84]
  input  logic        s_axis_tuser,  // func[0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,  // event_res[2:0], out_port[6:3], neighbor_id[22:7],
                                     // rtt[54:23], zero[55]
  output logic        m_axis_tlast
);

  logic [31:0] link_timeout_q;
  nlt_qstat_t  q_stat;
  nlt_cmd_t    push_cmd;
  nlt_cmd_t    head_cmd;
  logic        push;
  logic        pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_timeout_q <= TIMEOUT_RESET;
    end else if (cfg_we_i) begin
      link_timeout_q <= cfg_wdata_i;
    end
  end

  nlt_front #(
    .NUM_PORTS(NUM_PORTS)
  ) u_front (
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .q_stat_i     (q_stat),
    .push_o       (push),
    .cmd_o        (push_cmd)
  );

  nlt_fifo u_fifo (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push_i(push),
    .data_i(push_cmd),
    .pop_i (pop),
    .data_o(head_cmd),
    .stat_o(q_stat)
  );

  nlt_back #(
    .NUM_PORTS(NUM_PORTS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .link_timeout_i(link_timeout_q),
    .q_stat_i      (q_stat),
    .q_data_i      (head_cmd),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

`include "neighbor_liveness_table_top_assert.svh"

  // the queue is never both full and empty
  `NLT_ASSERT_IMPL(a_q_consistent, q_stat.full, !q_stat.empty, "queue full and empty")
  // a stable result always closes its item
  `NLT_ASSERT_IMPL(a_stable_last, m_axis_tvalid && (m_axis_tdata[2:0] == EV_STABLE),
                   m_axis_tlast, "stable result without last")
  // pong results are single and always last
  `NLT_ASSERT_IMPL(a_pong_last, m_axis_tvalid && (m_axis_tdata[2:0] != EV_DOWN),
                   m_axis_tlast, "pong result without last")
  // a pop only happens on a non-empty queue, and the queue then has room
  `NLT_ASSERT_NEXT(a_pop_room, pop, !q_stat.full, "queue full right after a pop")

endmodule

@@ verif/neighbor_liveness_table_checker.sv @@
// checker for the neighbor liveness table: predicts events from accepted words and compares
`timescale 1ns / 1ps
module neighbor_liveness_table_checker import nlt_pkg::*; #(
  parameter int NUM_PORTS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [87:0] s_axis_tdata,  // port[3:0], sender_id[19:4], sent_time[51:20],
                                     // now[83:52], zero[87:84]
  input  logic        s_axis_tuser,  // func[0]
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [55:0] m_axis_tdata,  // event_res[2:0], out_port[6:3], neighbor_id[22:7],
                                     // rtt[54:23], zero[55]
  input  logic        m_axis_tlast,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic [2:0]  ev;
    logic [3:0]  port;
    logic [15:0] id;
    logic [31:0] rtt;
    logic        last;
  } nlt_event_t;

  logic        live_q       [NUM_PORTS];
  logic [15:0] nbr_id_q     [NUM_PORTS];
  logic [31:0] nbr_rtt_q    [NUM_PORTS];
  logic [31:0] last_heard_q [NUM_PORTS];
  logic [31:0] link_timeout_q;

  nlt_event_t event_q [$];
  int fails = 0;

  // update the table for one word and queue the events it should produce
  task automatic table_update(input logic func, input logic [3:0] port,
                              input logic [15:0] sid, input logic [31:0] sent,
                              input logic [31:0] now);
    logic [31:0] rtt;
    logic [31:0] age;
    nlt_event_t  ev;
    nlt_event_t  downs [$];
    rtt = now - sent;
    if (func == FUNC_PONG) begin
      if (port >= NUM_PORTS) return;
      ev = '{ev: EV_NEW, port: port, id: sid, rtt: rtt, last: 1'b1};
      if (!live_q[port]) begin
        live_q[port]   = 1'b1;
        nbr_id_q[port] = sid;
        nbr_rtt_q[port] = rtt;
      end else if (nbr_rtt_q[port] != rtt) begin
        nbr_rtt_q[port] = rtt;
        ev.ev = EV_RTT_CHANGED;
      end else begin
        ev.ev = EV_REFRESHED;
      end
      last_heard_q[port] = now;
      event_q.insert(event_q.size(), ev);
    end else begin
      for (int i = 0; i < NUM_PORTS; i++) begin
        age = now - last_heard_q[i];
        if (live_q[i] && age > link_timeout_q) begin
          live_q[i] = 1'b0;
          ev = '{ev: EV_DOWN, port: 4'(i), id: nbr_id_q[i], rtt: nbr_rtt_q[i], last: 1'b0};
          downs.insert(downs.size(), ev);
        end
      end
      if (downs.size() == 0) begin
        ev = '{ev: EV_STABLE, port: 4'd0, id: 16'd0, rtt: 32'd0, last: 1'b1};
        event_q.insert(event_q.size(), ev);
      end else begin
        for (int k = 0; k < downs.size(); k++) begin
          ev = downs[k];
          ev.last = (k == downs.size() - 1);
          event_q.insert(event_q.size(), ev);
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    nlt_event_t got;
    nlt_event_t want;
    if (!rst_ni) begin
      for (int i = 0; i < NUM_PORTS; i++) begin
        live_q[i]       = 1'b0;
        nbr_id_q[i]     = '0;
        nbr_rtt_q[i]    = '0;
        last_heard_q[i] = '0;
      end
      link_timeout_q = TIMEOUT_RESET;
      event_q.delete();
    end else begin
      if (cfg_we_i) link_timeout_q = cfg_wdata_i;
      if (s_axis_tvalid && s_axis_tready) begin
        table_update(s_axis_tuser, s_axis_tdata[3:0], s_axis_tdata[19:4],
                     s_axis_tdata[51:20], s_axis_tdata[83:52]);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{ev: m_axis_tdata[2:0], port: m_axis_tdata[6:3], id: m_axis_tdata[22:7],
                rtt: m_axis_tdata[54:23], last: m_axis_tlast};
        if (event_q.size() == 0) begin
          fails++;
          $display("%0t: unexpected word ev=%0d port=%0d id=%h rtt=%h last=%b",
                   $time, got.ev, got.port, got.id, got.rtt, got.last);
        end else begin
          want = event_q.pop_front();
          if (got != want) begin
            fails++;
            $display("%0t: mismatch expected ev=%0d port=%0d id=%h rtt=%h last=%b",
                     $time, want.ev, want.port, want.id, want.rtt, want.last);
            $display("%0t:          actual   ev=%0d port=%0d id=%h rtt=%h last=%b",
                     $time, got.ev, got.port, got.id, got.rtt, got.last);
          end
        end
      end
    end
    fail_count_o = fails;
    pending_o    = event_q.size();
  end

endmodule

@@ verif/neighbor_liveness_table_top_tb.sv @@
// testbench top for the neighbor liveness table: stimulus, output stalls and verdict
`timescale 1ns / 1ps
module neighbor_liveness_table_top_tb;
  import nlt_pkg::*;

  localparam int NUM_PORTS = 16;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [31:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [87:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;
  logic        m_axis_tlast;
  int          fail_count;
  int          pending;

  neighbor_liveness_table_top #(.NUM_PORTS(NUM_PORTS)) i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast
  );

  neighbor_liveness_table_checker #(.NUM_PORTS(NUM_PORTS)) i_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    #5ms;
    $display("neighbor_liveness_table_top test failed");
    $finish;
  end

  // output side stalls, redrawn after every word
  int sink_gap = 0;
  bit sink_calm = 1'b0;
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      if ($urandom_range(0, 15) == 0) sink_calm = !sink_calm;
      sink_gap = sink_calm ? 0 : $urandom_range(0, 12);
    end else if (sink_gap > 0) begin
      sink_gap--;
    end
  end
  always @(negedge clk_i) begin
    m_axis_tready <= (sink_gap == 0);
  end

  logic [31:0] cur_time;
  logic [31:0] tmo;
  logic [31:0] heard_at [NUM_PORTS];
  logic [31:0] rtt_sent [NUM_PORTS];
  logic [31:0] phase_tmo [5];
  bit          src_calm = 1'b0;
  int          words_sent = 0;
  int          cfg_writes = 0;

  task automatic send_word(input logic func, input logic [3:0] port, input logic [15:0] sid,
                           input logic [31:0] sent, input logic [31:0] now);
    int gap;
    if (words_sent % 16 == 0) src_calm = ($urandom_range(0, 2) == 0);
    gap = src_calm ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= func;
    s_axis_tdata  <= {4'b0, now, sent, sid, port};
    do @(posedge clk_i); while (!s_axis_tready);
    words_sent++;
  endtask

  task automatic pong(input logic [3:0] port, input logic [15:0] sid, input logic [31:0] rtt);
    send_word(FUNC_PONG, port, sid, cur_time - rtt, cur_time);
    heard_at[port] = cur_time;
    rtt_sent[port] = rtt;
  endtask

  // port, id and send time are don't-care on a check, so they carry noise
  task automatic check_at(input logic [31:0] now);
    send_word(FUNC_CHECK, 4'($urandom), 16'($urandom), $urandom, now);
  endtask

  task automatic set_timeout(input logic [31:0] value);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (NUM_PORTS + 4) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    tmo = value;
    cfg_writes++;
  endtask

  task automatic random_item();
    int          r;
    logic [3:0]  p;
    logic [31:0] rtt;
    logic [31:0] span;
    span = (tmo <= 32'd2000) ? tmo / 2 + 1 : 32'd600;
    cur_time += ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, span);
    r = $urandom_range(0, 99);
    p = 4'($urandom);
    if (r < 60) begin
      case ($urandom_range(0, 4))
        0, 1:    rtt = rtt_sent[p];
        2, 3:    rtt = $urandom_range(0, 50);
        default: rtt = $urandom;
      endcase
      pong(p, 16'($urandom), rtt);
    end else if (r < 85) begin
      check_at(cur_time);
    end else if (r < 92) begin
      // age right at the timeout or one past it
      check_at(heard_at[p] + tmo + $urandom_range(0, 1));
    end else begin
      rtt = $urandom;
      send_word(FUNC_PONG, p, 16'($urandom), $urandom, rtt);
      heard_at[p] = rtt;
    end
  endtask

  initial begin
    for (int i = 0; i < NUM_PORTS; i++) begin
      heard_at[i] = '0;
      rtt_sent[i] = '0;
    end
    tmo = TIMEOUT_RESET;
    cur_time = 32'hFFFF_FE00;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty table, install, refresh, rtt change, wrap, boundary, full table
    check_at(cur_time);
    pong(4'd0, 16'h0000, 32'd0);
    pong(4'd15, 16'hFFFF, 32'hFFFF_FFFF);
    pong(4'd0, 16'h1234, 32'd0);
    pong(4'd0, 16'h5678, 32'd5);
    pong(4'd7, 16'hA5A5, cur_time);
    cur_time += 32'd1000;
    check_at(cur_time);
    check_at(cur_time + 32'd1);
    cur_time += 32'd1;
    set_timeout(32'd0);
    for (int i = 0; i < NUM_PORTS; i++) pong(4'(i), 16'($urandom), $urandom_range(0, 3));
    check_at(cur_time);
    check_at(cur_time + 32'd1);
    cur_time += 32'd1;
    set_timeout(32'hFFFF_FFFF);
    pong(4'd3, 16'h00FF, 32'd17);
    check_at(cur_time - 32'd1);

    phase_tmo[0] = 32'hFFFF_FFFF;
    phase_tmo[1] = $urandom_range(1, 2000);
    phase_tmo[2] = 32'd0;
    phase_tmo[3] = $urandom;
    phase_tmo[4] = TIMEOUT_RESET;
    for (int ph = 0; ph < 5; ph++) begin
      if (ph > 0) set_timeout(phase_tmo[ph]);
      repeat (60) random_item();
    end

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (NUM_PORTS + 8) @(negedge clk_i);
    $display("sent %0d pong and check words over %0d link timeout writes", words_sent,
             cfg_writes);
    $display("timeouts covered: reset value, zero, all ones and random values");
    if (fail_count == 0 && pending == 0) begin
      $display("neighbor_liveness_table_top test passed");
    end else begin
      $display("neighbor_liveness_table_top test failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/nlt_pkg.sv
rtl/nlt_front.sv
rtl/nlt_fifo.sv
rtl/nlt_back.sv
rtl/neighbor_liveness_table_top.sv
verif/neighbor_liveness_table_checker.sv
verif/neighbor_liveness_table_top_tb.sv
